// ===== design/tfa_pkg.sv =====
package tfa_pkg;

  localparam int unsigned TexelW   = 32;
  localparam int unsigned PixelW   = 16;
  localparam int unsigned FmtW     = 3;
  localparam int unsigned SizeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_RGBA = 3'd0,
    FMT_YUV  = 3'd1,
    FMT_CI   = 3'd2,
    FMT_IA   = 3'd3,
    FMT_I    = 3'd4
  } fmt_e;

  typedef enum logic [SizeW-1:0] {
    SZ_4  = 2'd0,
    SZ_8  = 2'd1,
    SZ_16 = 2'd2,
    SZ_32 = 2'd3
  } size_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FORMAT = 2'd0,
    REG_SIZE   = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [FmtW-1:0]  fmt;
    logic [SizeW-1:0] size;
  } cfg_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              supported;
  } result_t;

  localparam logic [FmtW-1:0]  FmtReset  = FMT_RGBA;
  localparam logic [SizeW-1:0] SizeReset = SZ_16;

  function automatic logic [PixelW-1:0] grey_word(logic [4:0] c, logic a);
    grey_word = {a, c, c, c};
  endfunction

  function automatic result_t convert(cfg_t cfg, logic [TexelW-1:0] t);
    result_t r;
    r.pixel     = '0;
    r.supported = 1'b1;
    case ({cfg.fmt, cfg.size})
      {FMT_RGBA, SZ_16}: r.pixel = {t[0], t[15:1]};
      {FMT_RGBA, SZ_32}: r.pixel = {t[7], t[31:27], t[23:19], t[15:11]};
      {FMT_I, SZ_8}:     r.pixel = grey_word(t[7:3], t[7]);
      {FMT_I, SZ_4}:     r.pixel = grey_word({t[3:0], t[3]}, t[3]);
      {FMT_IA, SZ_16}:   r.pixel = grey_word(t[15:11], t[7]);
      {FMT_IA, SZ_8}:    r.pixel = grey_word({t[7:4], t[7]}, t[3]);
      {FMT_IA, SZ_4}:    r.pixel = grey_word({t[3:1], t[3:2]}, t[0]);
      default: begin
        r.pixel     = '0;
        r.supported = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/texel_format_to_argb1555.sv =====
// Throughput: one texel per cycle while the master side accepts results; an input register and
// a result register pass the transaction on whenever the stage after them is empty or draining.
// Reset (rst_ni low, asynchronous): both stages empty, format RGBA, size sixteen bits.
module texel_format_to_argb1555
  import tfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TexelW-1:0]   s_axis_tdata,   // [31:0] texel_bits
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixelW-1:0]   m_axis_tdata,   // [15:0] pixel_argb
  output logic                m_axis_tuser,   // [0] format_supported
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              mid_valid;
  logic              mid_ready;
  logic [TexelW-1:0] mid_texel;
  result_t           result;

  tfa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tfa_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .valid_o   (mid_valid),
    .ready_i   (mid_ready),
    .data_o    (mid_texel)
  );

  tfa_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (mid_valid),
    .ready_o   (mid_ready),
    .texel_i   (mid_texel),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result)
  );

  assign m_axis_tdata = result.pixel;
  assign m_axis_tuser = result.supported;

endmodule

// ===== design/tfa_cfg_regs.sv =====
module tfa_cfg_regs
  import tfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FORMAT: cfg_d.fmt  = cfg_data_i[FmtW-1:0];
        REG_SIZE:   cfg_d.size = cfg_data_i[SizeW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt  <= FmtReset;
      cfg_q.size <= SizeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/tfa_in_stage.sv =====
module tfa_in_stage
  import tfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [TexelW-1:0] s_data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [TexelW-1:0] data_o
);

  logic              valid_q, valid_d;
  logic [TexelW-1:0] data_q, data_d;
  logic              load;

  assign s_ready_o = !valid_q || ready_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
    if (load) begin
      data_d = s_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tfa_out_stage.sv =====
module tfa_out_stage
  import tfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [TexelW-1:0] texel_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output result_t           result_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;
  logic    load;

  assign ready_o = !valid_q || m_ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
    if (load) begin
      res_d = convert(cfg_i, texel_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_valid_o = valid_q;
  assign result_o  = res_q;

endmodule

// ===== design/tfa_checker.sv =====
module tfa_checker
  import tfa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [PixelW-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  // unsupported pairs carry a zero pixel
  a_unsupported_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("unsupported result with non-zero pixel");

  // input back-pressure only when a result is waiting
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind texel_format_to_argb1555 tfa_checker u_tfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/texel_argb_checker.sv =====
module texel_argb_checker
  import tfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [TexelW-1:0]   s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [PixelW-1:0]   m_tdata_i,
  input  logic                m_tuser_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatch_count_o,
  output int                  pending_pixels_o
);

  logic [FmtW-1:0]  fmt_q;
  logic [SizeW-1:0] size_q;
  result_t          expected_pixels[$];

  // truncate each channel to its top five bits
  function automatic logic [PixelW-1:0] pack_argb(input logic alpha, input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue);
    return {alpha, red[7:3], green[7:3], blue[7:3]};
  endfunction

  function automatic result_t predict_argb1555(input logic [FmtW-1:0] fmt,
                                               input logic [SizeW-1:0] sz,
                                               input logic [TexelW-1:0] t);
    result_t    r;
    logic [7:0] lum;
    logic       alpha;
    r.pixel     = '0;
    r.supported = 1'b1;
    lum         = t[7:0];
    alpha       = 1'b0;
    if (fmt == FMT_RGBA && sz == SZ_16) begin
      r.pixel = {t[0], t[15:1]};
    end else if (fmt == FMT_RGBA && sz == SZ_32) begin
      r.pixel = pack_argb(t[7:0] >= 8'd128, t[31:24], t[23:16], t[15:8]);
    end else begin
      if (fmt == FMT_I && sz == SZ_8) begin
        lum   = t[7:0];
        alpha = t[7:0] >= 8'd128;
      end else if (fmt == FMT_I && sz == SZ_4) begin
        lum   = t[3:0] * 8'd17;
        alpha = t[3:0] >= 4'd8;
      end else if (fmt == FMT_IA && sz == SZ_16) begin
        lum   = t[15:8];
        alpha = t[7:0] >= 8'd128;
      end else if (fmt == FMT_IA && sz == SZ_8) begin
        lum   = t[7:4] * 8'd17;
        alpha = t[3:0] >= 4'd8;
      end else if (fmt == FMT_IA && sz == SZ_4) begin
        // widen three intensity bits to eight by replication
        lum   = {t[3:1], t[3:1], t[3:2]};
        alpha = t[0];
      end else begin
        r.supported = 1'b0;
      end
      if (r.supported) begin
        r.pixel = pack_argb(alpha, lum, lum, lum);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      fmt_q            = FmtReset;
      size_q           = SizeReset;
      mismatch_count_o = 0;
      pending_pixels_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_argb: no transaction expected, actual %h", m_tdata_i);
          mismatch_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata_i !== want.pixel) begin
            $error("pixel_argb: expected %h, actual %h", want.pixel, m_tdata_i);
            mismatch_count_o++;
          end
          if (m_tuser_i !== want.supported) begin
            $error("format_supported: expected %b, actual %b", want.supported, m_tuser_i);
            mismatch_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_pixels.push_back(predict_argb1555(fmt_q, size_q, s_tdata_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FORMAT: fmt_q = cfg_data_i[FmtW-1:0];
          REG_SIZE:   size_q = cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      pending_pixels_o = expected_pixels.size();
    end
  end

endmodule

// ===== tb/texel_format_to_argb1555_tb.sv =====
module texel_format_to_argb1555_tb;
  import tfa_pkg::*;

  localparam int unsigned RandomItems = 2000;
  localparam int unsigned QuietLimit  = 2000;

  localparam logic [FmtW-1:0]    FmtUnused7 = 3'd7;
  localparam logic [CfgIdxW-1:0] RegSpare2  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3  = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TexelW-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixelW-1:0]   m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = REG_FORMAT;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int          mismatch_count;
  int          pending_pixels;
  int          quiet_cycles  = 0;
  int          burst_left    = 1;
  bit          steady_sender = 1'b1;
  logic [15:0] stall_mask    = 16'hFFFF;
  logic [3:0]  stall_phase   = '0;

  always #1 clk_i = ~clk_i;

  texel_format_to_argb1555 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  texel_argb_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_pixels_o (pending_pixels)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= stall_mask[stall_phase];
    stall_phase   <= stall_phase + 4'd1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // call at a falling edge; returns at a falling edge after the transaction
  task automatic push_texel(input logic [TexelW-1:0] texel);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= texel;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    if (!steady_sender && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // drain all pending pixels before touching the registers
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_pixels != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic convert_boundaries(input logic [FmtW-1:0] fmt, input logic [SizeW-1:0] sz);
    write_reg(REG_FORMAT, fmt);
    write_reg(REG_SIZE, {1'b0, sz});
    push_texel(32'h7F7F_7F7F);
    push_texel(32'h8080_8080);
  endtask

  initial begin : stimulus
    int               sent;
    int               phase_len;
    logic [FmtW-1:0]  fmt;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_texel(32'h0000_0000);
    push_texel(32'hFFFF_FFFF);
    convert_boundaries(FMT_RGBA, SZ_32);
    convert_boundaries(FMT_I, SZ_8);
    convert_boundaries(FMT_I, SZ_4);
    convert_boundaries(FMT_IA, SZ_16);
    convert_boundaries(FMT_IA, SZ_8);
    convert_boundaries(FMT_IA, SZ_4);
    convert_boundaries(FMT_RGBA, SZ_16);

    write_reg(REG_FORMAT, FMT_CI);
    write_reg(REG_SIZE, {1'b0, SZ_8});
    push_texel(32'hFFFF_FFFF);
    write_reg(REG_FORMAT, FMT_YUV);
    write_reg(REG_SIZE, {1'b0, SZ_16});
    push_texel(32'hFFFF_FFFF);
    write_reg(REG_FORMAT, FmtUnused7);
    write_reg(REG_SIZE, {1'b0, SZ_32});
    push_texel(32'hFFFF_FFFF);
    write_reg(REG_FORMAT, FMT_I);
    write_reg(REG_SIZE, {1'b0, SZ_16});
    push_texel(32'hFFFF_FFFF);

    // out-of-range index must leave I8 in place
    write_reg(REG_SIZE, {1'b0, SZ_8});
    write_reg(RegSpare2, FMT_RGBA);
    write_reg(RegSpare3, {1'b0, SZ_32});
    push_texel(32'h0000_00F0);
    // top data bit of a size write is dropped
    write_reg(REG_SIZE, {1'b1, SZ_4});
    push_texel(32'h0000_0009);

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fmt = FMT_RGBA;
        3, 4, 5: fmt = FMT_IA;
        6, 7, 8: fmt = FMT_I;
        default: fmt = FmtW'($urandom_range(0, 7));
      endcase
      write_reg(REG_FORMAT, fmt);
      write_reg(REG_SIZE, CfgDataW'($urandom_range(0, 7)));
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? RegSpare2 : RegSpare3,
                  CfgDataW'($urandom_range(0, 7)));
      end
      stall_mask    = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                      (16'($urandom()) | 16'h0001);
      steady_sender = ($urandom_range(0, 3) == 0);
      burst_left    = $urandom_range(1, 24);
      phase_len     = $urandom_range(20, 250);
      repeat (phase_len) begin
        push_texel($urandom());
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
